// ----- design/swg_pkg.sv -----
// ----------------------------------------------------------------------------
// swg_pkg
// Shared types, constants and arithmetic helpers of the spiral waypoint
// generator.
// ----------------------------------------------------------------------------
package swg_pkg;

   localparam int SWG_CORDIC_STAGES = 24;
   localparam int SWG_ATAN_IDX_W    = 5;
   localparam int SWG_CSR_ADDR_W    = 4;

   localparam logic        OP_START       = 1'b0;
   localparam logic [31:0] QUARTER_TURN   = 32'h4000_0000;
   localparam logic [31:0] EIGHTH_TURN    = 32'h2000_0000;
   localparam logic [47:0] START_RADIUS   = 48'h0001_8000_0000;
   localparam logic [47:0] RADIUS_MAX     = 48'hFFFF_FFFF_FFFF;
   localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

   localparam logic [31:0] RST_MAX_RADIUS   = 32'd983040;
   localparam logic [31:0] RST_LOOP_SPACING = 32'd131072;
   localparam logic [30:0] RST_ANGLE_STEP   = 31'd341782638;

   // arctangent of 2^-i in binary turns
   localparam logic [31:0] SWG_ATAN_TURNS [32] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81,
      32'd41,        32'd20,        32'd10,        32'd5,
      32'd3,         32'd1,         32'd1,         32'd0
   };

   typedef enum logic [1:0] {
      REG_MAX_RADIUS   = 2'd0,
      REG_LOOP_SPACING = 2'd1,
      REG_ANGLE_STEP   = 2'd2
   } swg_reg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INC_MUL,
      ST_INC_LOAD,
      ST_CHECK,
      ST_ROT_POS,
      ST_MUL_X,
      ST_MUL_Y,
      ST_POS_Y,
      ST_ROT_QUAT,
      ST_OUT
   } swg_state_type;

   typedef enum logic [1:0] {
      MUL_INC,
      MUL_COS,
      MUL_SIN
   } swg_mul_sel_type;

   typedef struct packed {
      logic        start;
      logic [31:0] angle;
   } swg_rot_req_type;

   typedef struct packed {
      logic               done;
      logic signed [31:0] cos_v;
      logic signed [31:0] sin_v;
   } swg_rot_rsp_type;

   // origin + round(prod / 2^30), saturated to 32 bits signed
   function automatic logic signed [31:0] swg_place(input logic [31:0]        origin,
                                                    input logic signed [65:0] prod);
      logic signed [65:0] rnd;
      logic signed [65:0] sum;
      rnd = (prod + 66'sd536870912) >>> 30;
      sum = 66'($signed(origin)) + rnd;
      if (sum > 66'sd2147483647) begin
         return 32'sh7FFF_FFFF;
      end else if (sum < -66'sd2147483648) begin
         return 32'sh8000_0000;
      end else begin
         return sum[31:0];
      end
   endfunction

   // Q2.30 to Q1.15, rounded and saturated
   function automatic logic signed [15:0] swg_to_q15(input logic signed [31:0] v);
      logic signed [33:0] t;
      t = (34'(v) + 34'sd16384) >>> 15;
      if (t > 34'sd32767) begin
         return 16'sh7FFF;
      end else if (t < -34'sd32768) begin
         return 16'sh8000;
      end else begin
         return t[15:0];
      end
   endfunction

endpackage

// ----- design/swg_cordic.sv -----
// ----------------------------------------------------------------------------
// swg_cordic
// Iterative CORDIC rotation, one micro-rotation per cycle, giving cosine and
// sine of a binary angle in Q2.30.
// ----------------------------------------------------------------------------
module swg_cordic #(
   parameter int STAGES = swg_pkg::SWG_CORDIC_STAGES
) (
   input  logic                     clock,
   input  logic                     reset,
   input  swg_pkg::swg_rot_req_type rot_req,
   output swg_pkg::swg_rot_rsp_type rot_rsp
);
   import swg_pkg::*;

   localparam int CNT_W = $clog2(STAGES + 1);

   logic signed [33:0]        x_ff, x_in;
   logic signed [33:0]        y_ff, y_in;
   logic signed [33:0]        z_ff, z_in;
   logic [1:0]                quad_ff, quad_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;

   logic [SWG_ATAN_IDX_W-1:0] idx;
   logic signed [33:0]        dx, dy, atan_v;
   logic [31:0]               quad_base;
   logic [31:0]               z_start;
   logic signed [33:0]        cos_w, sin_w;

   assign idx       = SWG_ATAN_IDX_W'(cnt_ff);
   assign dx        = y_ff >>> idx;
   assign dy        = x_ff >>> idx;
   assign atan_v    = $signed({2'b00, SWG_ATAN_TURNS[idx]});
   assign quad_base = rot_req.angle + EIGHTH_TURN;
   assign z_start   = rot_req.angle - {quad_base[31:30], 30'd0};

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      quad_in = quad_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (rot_req.start) begin
         x_in    = CORDIC_X0;
         y_in    = '0;
         z_in    = 34'($signed(z_start));
         quad_in = quad_base[31:30];
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!z_ff[33]) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - atan_v;
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + atan_v;
         end
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(STAGES - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      quad_ff <= quad_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // quadrant fold-back
   always_comb begin
      case (quad_ff)
         2'd0: begin
            cos_w = x_ff;
            sin_w = y_ff;
         end
         2'd1: begin
            cos_w = -y_ff;
            sin_w = x_ff;
         end
         2'd2: begin
            cos_w = -x_ff;
            sin_w = -y_ff;
         end
         default: begin
            cos_w = y_ff;
            sin_w = -x_ff;
         end
      endcase
   end

   assign rot_rsp.done  = done_ff;
   assign rot_rsp.cos_v = cos_w[31:0];
   assign rot_rsp.sin_v = sin_w[31:0];

endmodule

// ----- design/spiral_waypoint_generator_core.sv -----
// ----------------------------------------------------------------------------
// spiral_waypoint_generator_core
// Archimedean spiral waypoint generator: one waypoint item per input item.
// A new input item is stalled (req_stall) until the sequencer is back in idle,
// i.e. until the previous result has entered the output register, so items are
// not overlapped. A start item first computes the radius step; the shared CORDIC
// runs twice per emitted waypoint. Synchronous reset loads the register defaults
// and clears the spiral; no clearing pass.
// ----------------------------------------------------------------------------
module spiral_waypoint_generator_core #(
   parameter int CORDIC_STAGES = swg_pkg::SWG_CORDIC_STAGES
) (
   input  logic                               clock,
   input  logic                               reset,
   // input item channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_opcode,
   input  logic signed [31:0]                 req_origin_x,
   input  logic signed [31:0]                 req_origin_y,
   input  logic [31:0]                        req_start_heading,
   // result item channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_point_valid,
   output logic signed [31:0]                 rsp_pos_x,
   output logic signed [31:0]                 rsp_pos_y,
   output logic [31:0]                        rsp_tangent_heading,
   output logic signed [15:0]                 rsp_quat_z,
   output logic signed [15:0]                 rsp_quat_w,
   output logic                               rsp_last_point,
   // register port
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [swg_pkg::SWG_CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                        pwdata,
   output logic [31:0]                        prdata,
   output logic                               pready
);
   import swg_pkg::*;

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [31:0]  max_radius_ff;
   logic [31:0]  loop_spacing_ff;
   logic [30:0]  angle_step_ff;
   swg_reg_type  reg_sel;
   logic         csr_wr;

   assign pready  = 1'b1;
   assign reg_sel = swg_reg_type'(paddr[3:2]);
   assign csr_wr  = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_radius_ff   <= RST_MAX_RADIUS;
         loop_spacing_ff <= RST_LOOP_SPACING;
         angle_step_ff   <= RST_ANGLE_STEP;
      end else if (csr_wr) begin
         unique case (reg_sel)
            REG_MAX_RADIUS:   max_radius_ff   <= pwdata;
            REG_LOOP_SPACING: loop_spacing_ff <= pwdata;
            REG_ANGLE_STEP:   angle_step_ff   <= pwdata[30:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_MAX_RADIUS:   prdata = max_radius_ff;
         REG_LOOP_SPACING: prdata = loop_spacing_ff;
         REG_ANGLE_STEP:   prdata = {1'b0, angle_step_ff};
         default:          prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Spiral state
   // ---------------------------------------------------------------------
   logic [31:0]  center_x_ff, center_y_ff;
   logic [31:0]  base_heading_ff;
   logic [31:0]  spiral_phase_ff;
   logic [47:0]  radius_accum_ff;
   logic [47:0]  radius_increment_ff;
   logic         spiral_active_ff;

   swg_state_type state_ff, state_in;
   logic          req_take;

   // working result of the item in flight
   logic               wk_point_valid_ff;
   logic signed [31:0] wk_pos_x_ff, wk_pos_y_ff;
   logic [31:0]        wk_heading_ff;
   logic signed [15:0] wk_quat_z_ff, wk_quat_w_ff;
   logic               wk_last_ff;

   // output register
   logic               rsp_valid_ff;
   logic               out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid & ~req_stall;
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;

   // derived values
   logic [31:0]  yaw;
   logic [47:0]  limit;
   logic [48:0]  radius_sum;
   logic [47:0]  radius_next;
   logic         point_ok;

   assign yaw         = base_heading_ff + spiral_phase_ff;
   assign limit       = {max_radius_ff, 16'd0};
   assign radius_sum  = {1'b0, radius_accum_ff} + {1'b0, radius_increment_ff};
   assign radius_next = radius_sum[48] ? RADIUS_MAX : radius_sum[47:0];
   assign point_ok    = spiral_active_ff && (loop_spacing_ff != '0) &&
                        (radius_accum_ff <= limit);

   // CORDIC request and response
   swg_rot_req_type rot_req;
   swg_rot_rsp_type rot_rsp;

   // ---------------------------------------------------------------------
   // Shared multiplier: radius step once per spiral, then r*cos and r*sin
   // ---------------------------------------------------------------------
   swg_mul_sel_type    mul_sel;
   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] product_ff, product_in;

   always_comb begin
      case (mul_sel)
         MUL_COS: begin
            mul_a = $signed({1'b0, radius_accum_ff[47:16]});
            mul_b = 33'(rot_rsp.cos_v);
         end
         MUL_SIN: begin
            mul_a = $signed({1'b0, radius_accum_ff[47:16]});
            mul_b = 33'(rot_rsp.sin_v);
         end
         default: begin
            mul_a = $signed({1'b0, loop_spacing_ff});
            mul_b = $signed({2'b00, angle_step_ff});
         end
      endcase
      product_in = mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   // ---------------------------------------------------------------------
   // Shared CORDIC unit
   // ---------------------------------------------------------------------
   swg_cordic #(
      .STAGES (CORDIC_STAGES)
   ) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .rot_req (rot_req),
      .rot_rsp (rot_rsp)
   );

   // ---------------------------------------------------------------------
   // Sequencer: next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = (req_opcode == OP_START) ? ST_INC_MUL : ST_CHECK;
            end
         end
         ST_INC_MUL:  state_in = ST_INC_LOAD;
         ST_INC_LOAD: state_in = ST_CHECK;
         ST_CHECK:    state_in = point_ok ? ST_ROT_POS : ST_OUT;
         ST_ROT_POS: begin
            if (rot_rsp.done) begin
               state_in = ST_MUL_X;
            end
         end
         ST_MUL_X:    state_in = ST_MUL_Y;
         ST_MUL_Y:    state_in = ST_POS_Y;
         ST_POS_Y:    state_in = ST_ROT_QUAT;
         ST_ROT_QUAT: begin
            if (rot_rsp.done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------
   // Sequencer: control outputs
   // ---------------------------------------------------------------------
   always_comb begin
      rot_req.start = 1'b0;
      rot_req.angle = yaw + QUARTER_TURN;
      mul_sel       = MUL_INC;
      unique case (state_ff)
         ST_CHECK: begin
            rot_req.start = point_ok;
         end
         ST_MUL_X: begin
            mul_sel = MUL_COS;
         end
         ST_MUL_Y: begin
            mul_sel = MUL_SIN;
         end
         ST_POS_Y: begin
            // half yaw for the quaternion
            rot_req.start = 1'b1;
            rot_req.angle = {1'b0, yaw[31:1]};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------------------------------------------------------------
   // Datapath
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff         <= '0;
         center_y_ff         <= '0;
         base_heading_ff     <= '0;
         spiral_phase_ff     <= '0;
         radius_accum_ff     <= '0;
         radius_increment_ff <= '0;
         spiral_active_ff    <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_take && (req_opcode == OP_START)) begin
                  center_x_ff      <= req_origin_x;
                  center_y_ff      <= req_origin_y;
                  base_heading_ff  <= req_start_heading;
                  spiral_phase_ff  <= '0;
                  radius_accum_ff  <= START_RADIUS;
                  spiral_active_ff <= 1'b1;
               end
            end
            ST_INC_LOAD: begin
               // spacing * step, truncated to Q16.32
               radius_increment_ff <= product_ff[63:16];
            end
            ST_CHECK: begin
               if (!point_ok) begin
                  spiral_active_ff <= 1'b0;
               end
            end
            ST_ROT_QUAT: begin
               if (rot_rsp.done) begin
                  spiral_phase_ff <= spiral_phase_ff + {1'b0, angle_step_ff};
                  radius_accum_ff <= radius_next;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_CHECK: begin
            wk_point_valid_ff <= point_ok;
         end
         ST_MUL_Y: begin
            wk_pos_x_ff <= swg_place(center_x_ff, product_ff);
         end
         ST_POS_Y: begin
            wk_pos_y_ff <= swg_place(center_y_ff, product_ff);
         end
         ST_ROT_QUAT: begin
            if (rot_rsp.done) begin
               wk_heading_ff <= yaw;
               wk_quat_z_ff  <= swg_to_q15(rot_rsp.sin_v);
               wk_quat_w_ff  <= swg_to_q15(rot_rsp.cos_v);
               wk_last_ff    <= (radius_next > limit);
            end
         end
         default: ;
      endcase
   end

   // ---------------------------------------------------------------------
   // Output register; a rejected point carries all-zero fields
   // ---------------------------------------------------------------------
   logic load_out;

   assign load_out = (state_ff == ST_OUT) && out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_point_valid     <= wk_point_valid_ff;
         rsp_pos_x           <= wk_point_valid_ff ? wk_pos_x_ff   : '0;
         rsp_pos_y           <= wk_point_valid_ff ? wk_pos_y_ff   : '0;
         rsp_tangent_heading <= wk_point_valid_ff ? wk_heading_ff : '0;
         rsp_quat_z          <= wk_point_valid_ff ? wk_quat_z_ff  : '0;
         rsp_quat_w          <= wk_point_valid_ff ? wk_quat_w_ff  : '0;
         rsp_last_point      <= wk_point_valid_ff & wk_last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
